FILE: design/pca_pkg.sv
// shared types and codes for the page chunk allocator
`timescale 1ns / 1ps
package pca_pkg;

	typedef enum logic [2:0] {
		ST_OK     = 3'd0,
		ST_ZERO   = 3'd1,
		ST_UNSUP  = 3'd2,
		ST_OOM    = 3'd3,
		ST_BADPTR = 3'd4,
		ST_DOUBLE = 3'd5
	} status_t;

	typedef enum logic {
		CMD_ALLOC = 1'b0,
		CMD_FREE  = 1'b1
	} cmd_t;

	localparam logic CFG_FRAME_BASE  = 1'b0;
	localparam logic CFG_POOL_FRAMES = 1'b1;

	typedef struct packed {
		logic        command;
		logic [15:0] request_size;
		logic [31:0] chunk_address;
	} req_t;

	typedef struct packed {
		status_t     status;
		logic [31:0] result_address;
	} rsp_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DIV,
		S_CHECK,
		S_SCAN_A,
		S_OPEN,
		S_CLEAR,
		S_MRD,
		S_MCK,
		S_ADDR1,
		S_ADDR2,
		S_SCAN_F,
		S_FCHK,
		S_FRD,
		S_FCK
	} fsm_t;

endpackage

FILE: design/pca_ram.sv
// generic simple dual port ram with registered read
`timescale 1ns / 1ps
module pca_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 4096,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: design/page_chunk_allocator.sv
// page chunk allocator top level: sequencer, shared divider, frame tables, chunk map
//
// channel   | signals                          | handshake
// request   | start, busy, request             | taken when start && !busy
// result    | done, result                     | one cycle strobe, no back pressure
// config    | cfg_we, cfg_index, cfg_data      | written when cfg_we is high
//
// one request at a time; busy drops in the cycle of the result strobe, and a request
//   rejected at once (zero size, oversize, null free) never raises busy
// alloc: the divider, one check, a scan of the open frames, an open step and a clear of the
//   map of a new frame, then a read and a check per map bit probed, then the address steps
// free: a scan of the open frames, the divider, one check, a read of the map bit and its clear
// the divider is bit-serial and the chunk map is a single one-bit-wide ram
// arst_n clears control state; the frame tables hold garbage until a frame opens
`timescale 1ns / 1ps
module page_chunk_allocator
	import pca_pkg::*;
#(
	parameter int NUM_FRAMES   = 16,
	parameter int PAGE_BYTES   = 4096,
	parameter int HEADER_BYTES = 24,
	parameter int MAX_CHUNKS   = 256
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  req_t        request,
	output logic        done,
	output rsp_t        result,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [31:0] cfg_data
);

	localparam int USABLE = PAGE_BYTES - HEADER_BYTES;
	localparam int DW     = $clog2(PAGE_BYTES + 1);
	localparam int CW     = $clog2(MAX_CHUNKS + 1);
	localparam int KW     = (MAX_CHUNKS > 1) ? $clog2(MAX_CHUNKS) : 1;
	localparam int FW     = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
	localparam int FCW    = $clog2(NUM_FRAMES + 1);
	localparam int MDEPTH = NUM_FRAMES * MAX_CHUNKS;
	localparam int MAW    = (MDEPTH > 1) ? $clog2(MDEPTH) : 1;
	localparam int DCW    = $clog2(DW + 1);

	fsm_t state_q, state_nxt;

	// configuration
	logic [31:0] base_q;
	logic [4:0]  pool_q;

	// request and working registers
	logic          cmd_q;
	logic [15:0]   size_q;
	logic [31:0]   addr_q;
	logic [15:0]   rem_q;
	logic [DW-1:0] quo_q;
	logic [15:0]   dvs_q;
	logic [DCW-1:0] dcnt_q;
	logic [FCW-1:0] fidx_q;
	logic [FCW-1:0] fiu_q;
	logic [FW-1:0]  f_q;
	logic [CW-1:0]  k_q;
	logic [31:0]    fstart_q;
	logic [31:0]    prod_q;
	logic [31:0]    fofs_q;
	logic [CW-1:0]  tot_q;

	// frame tables
	logic [15:0]   size_tab_q [NUM_FRAMES];
	logic [CW-1:0] tot_tab_q  [NUM_FRAMES];
	logic [CW-1:0] free_tab_q [NUM_FRAMES];

	// chunk map port
	logic           map_we;
	logic [MAW-1:0] map_waddr;
	logic           map_wdata;
	logic [MAW-1:0] map_raddr;
	logic           map_rdata;

	// finish signals
	logic        fin;
	status_t     fin_st;
	logic [31:0] fin_addr;
	logic        done_q;
	rsp_t        result_q;

	// shared divider step
	logic [16:0] div_cand;
	logic        div_ge;
	logic [15:0] div_rem;

	// scan helpers
	logic [FCW-1:0] g_idx;
	logic [FW-1:0]  gi;
	logic [FW-1:0]  fi;
	logic           hit_a;
	logic           pool_full;
	logic [31:0]    off;
	logic [31:0]    first;
	logic           hit_f;
	logic [MAW-1:0] map_addr;
	logic           last_clear;

	assign div_cand = {rem_q, quo_q[DW-1]};
	assign div_ge   = div_cand >= {1'b0, dvs_q};
	assign div_rem  = div_ge ? 16'(div_cand - {1'b0, dvs_q}) : div_cand[15:0];

	assign g_idx     = fidx_q - FCW'(1);
	assign gi        = g_idx[FW-1:0];
	assign fi        = fidx_q[FW-1:0];
	assign hit_a     = (size_tab_q[gi] == size_q) && (free_tab_q[gi] != '0);
	assign pool_full = 32'(fiu_q) >= ((32'(pool_q) < 32'(NUM_FRAMES)) ?
		32'(pool_q) : 32'(NUM_FRAMES));
	assign off       = addr_q - fstart_q;
	assign first     = 32'(HEADER_BYTES) + 32'(tot_tab_q[fi]);
	assign hit_f     = (off >= first) && (off < 32'(PAGE_BYTES));
	assign map_addr  = MAW'(32'(f_q) * 32'(MAX_CHUNKS) + 32'(k_q[KW-1:0]));
	assign last_clear = 32'(k_q) == 32'(MAX_CHUNKS - 1);

	pca_ram #(
		.WIDTH(1),
		.DEPTH(MDEPTH)
	) u_map (
		.clk  (clk),
		.we   (map_we),
		.waddr(map_waddr),
		.wdata(map_wdata),
		.raddr(map_raddr),
		.rdata(map_rdata)
	);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// next state, finish and map port control
	always_comb begin
		state_nxt = state_q;
		fin       = 1'b0;
		fin_st    = ST_OK;
		fin_addr  = '0;
		map_we    = 1'b0;
		map_waddr = map_addr;
		map_wdata = 1'b0;
		map_raddr = map_addr;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					if (request.command == CMD_ALLOC) begin
						if (request.request_size == '0) begin
							fin    = 1'b1;
							fin_st = ST_ZERO;
						end else if (32'(request.request_size) >= 32'(USABLE)) begin
							fin    = 1'b1;
							fin_st = ST_UNSUP;
						end else begin
							state_nxt = S_DIV;
						end
					end else if (request.chunk_address == '0) begin
						fin    = 1'b1;
						fin_st = ST_ZERO;
					end else begin
						state_nxt = S_SCAN_F;
					end
				end
			end
			S_DIV: begin
				if (dcnt_q == DCW'(1)) begin
					state_nxt = (cmd_q == CMD_ALLOC) ? S_CHECK : S_FCHK;
				end
			end
			S_CHECK: begin
				if (32'(rem_q) < 32'(quo_q) || 32'(quo_q) > 32'(MAX_CHUNKS)) begin
					fin    = 1'b1;
					fin_st = ST_UNSUP;
				end else begin
					state_nxt = S_SCAN_A;
				end
			end
			S_SCAN_A: begin
				if (fidx_q == '0) begin
					if (pool_full) begin
						fin    = 1'b1;
						fin_st = ST_OOM;
					end else begin
						state_nxt = S_OPEN;
					end
				end else if (hit_a) begin
					state_nxt = S_MRD;
				end
			end
			S_OPEN: state_nxt = S_CLEAR;
			S_CLEAR: begin
				map_we = 1'b1;
				if (last_clear) begin
					state_nxt = S_MRD;
				end
			end
			S_MRD: state_nxt = S_MCK;
			S_MCK: begin
				if (!map_rdata) begin
					map_we    = 1'b1;
					map_wdata = 1'b1;
					state_nxt = S_ADDR1;
				end else if (32'(k_q) + 32'd1 >= 32'(tot_tab_q[f_q])) begin
					fin    = 1'b1;
					fin_st = ST_OOM;
				end else begin
					state_nxt = S_MRD;
				end
			end
			S_ADDR1: state_nxt = S_ADDR2;
			S_ADDR2: begin
				fin      = 1'b1;
				fin_st   = ST_OK;
				fin_addr = base_q + fofs_q + 32'(HEADER_BYTES) + 32'(tot_q) + prod_q;
			end
			S_SCAN_F: begin
				if (fidx_q == fiu_q) begin
					fin    = 1'b1;
					fin_st = ST_BADPTR;
				end else if (hit_f) begin
					state_nxt = S_DIV;
				end
			end
			S_FCHK: begin
				if (rem_q != '0 || 32'(quo_q) >= 32'(tot_tab_q[f_q])) begin
					fin    = 1'b1;
					fin_st = ST_BADPTR;
				end else begin
					state_nxt = S_FRD;
				end
			end
			S_FRD: state_nxt = S_FCK;
			S_FCK: begin
				fin = 1'b1;
				if (!map_rdata) begin
					fin_st = ST_DOUBLE;
				end else begin
					map_we = 1'b1;
					fin_st = ST_OK;
				end
			end
			default: state_nxt = S_IDLE;
		endcase
		if (fin) begin
			state_nxt = S_IDLE;
		end
	end

	// control registers: config, frame count, result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			pool_q <= 5'd16;
			fiu_q  <= '0;
			done_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_FRAME_BASE) begin
					base_q <= cfg_data;
				end else begin
					pool_q <= cfg_data[4:0];
				end
			end
			if (state_q == S_OPEN) begin
				fiu_q <= fiu_q + FCW'(1);
			end
			done_q <= fin;
		end
	end

	// datapath and frame tables
	always_ff @(posedge clk) begin
		if (fin) begin
			result_q.status         <= fin_st;
			result_q.result_address <= fin_addr;
		end
		case (state_q)
			S_IDLE: begin
				cmd_q    <= request.command;
				size_q   <= request.request_size;
				addr_q   <= request.chunk_address;
				quo_q    <= DW'(USABLE);
				rem_q    <= '0;
				dvs_q    <= request.request_size;
				dcnt_q   <= DCW'(DW);
				fidx_q   <= '0;
				fstart_q <= base_q;
			end
			S_DIV: begin
				rem_q  <= div_rem;
				quo_q  <= {quo_q[DW-2:0], div_ge};
				dcnt_q <= dcnt_q - DCW'(1);
			end
			S_CHECK: begin
				tot_q  <= CW'(quo_q);
				fidx_q <= fiu_q;
			end
			S_SCAN_A: begin
				if (fidx_q != '0) begin
					fidx_q <= g_idx;
					f_q    <= gi;
					k_q    <= '0;
				end
			end
			S_OPEN: begin
				f_q               <= fiu_q[FW-1:0];
				size_tab_q[fiu_q[FW-1:0]] <= size_q;
				tot_tab_q[fiu_q[FW-1:0]]  <= tot_q;
				free_tab_q[fiu_q[FW-1:0]] <= tot_q;
				k_q               <= '0;
			end
			S_CLEAR: begin
				k_q <= last_clear ? '0 : k_q + CW'(1);
			end
			S_MCK: begin
				if (!map_rdata) begin
					free_tab_q[f_q] <= free_tab_q[f_q] - CW'(1);
				end else begin
					k_q <= k_q + CW'(1);
				end
			end
			S_ADDR1: begin
				prod_q <= 32'(k_q) * 32'(size_tab_q[f_q]);
				fofs_q <= 32'(f_q) * 32'(PAGE_BYTES);
				tot_q  <= tot_tab_q[f_q];
			end
			S_SCAN_F: begin
				if (hit_f) begin
					f_q    <= fi;
					quo_q  <= DW'(off - first);
					rem_q  <= '0;
					dvs_q  <= size_tab_q[fi];
					dcnt_q <= DCW'(DW);
				end else begin
					fidx_q   <= fidx_q + FCW'(1);
					fstart_q <= fstart_q + 32'(PAGE_BYTES);
				end
			end
			S_FCHK: begin
				k_q <= CW'(quo_q);
			end
			S_FCK: begin
				if (map_rdata) begin
					free_tab_q[f_q] <= free_tab_q[f_q] + CW'(1);
				end
			end
			default: begin
			end
		endcase
	end

	assign busy   = state_q != S_IDLE;
	assign done   = done_q;
	assign result = result_q;

`ifndef SYNTHESIS
	// the result strobe only comes with the block ready again
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// an accepted transaction either keeps the block busy or finishes at once
	a_start_progress: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy || done)
		else $error("accepted transaction lost");

	// never more frames open than NUM_FRAMES
	a_frames_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(fiu_q) <= 32'(NUM_FRAMES))
		else $error("frame count overflow");
`endif

endmodule
